### hdl/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared constants and types for the MT19937 word generator: pool geometry,
// twist and temper masks, command codes and the queue entry format.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int STATE_WORDS   = 624;
    localparam int MIDDLE_OFFSET = 397;
    localparam int ADDR_W        = $clog2(STATE_WORDS);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] POOL_END  = ADDR_W'(STATE_WORDS);
    localparam logic [ADDR_W-1:0] MID_START = ADDR_W'(MIDDLE_OFFSET);

    localparam logic [31:0] TWIST_MATRIX  = 32'h9908_b0df;
    localparam logic [31:0] TOP_BIT_MASK  = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS_MASK = 32'h7fff_ffff;
    localparam logic [31:0] TEMPER_B      = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C      = 32'hefc6_0000;
    localparam logic [31:0] SEED_MUL      = 32'd1812433253;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_SEED = 1'b0,
        CMD_NEXT = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] seed;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

### hdl/mtg_front.sv
// ----------------------------------------------------------------------------
// mtg_front
// Input side: takes item transfers, tags each as seed or request and holds
// them in a short queue until the engine pops them.
// ----------------------------------------------------------------------------
module mtg_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                action,
    input  logic [31:0]         seed_value,
    output mtg_pkg::head_t      head,
    input  logic                pop
);

    mtg_pkg::item_t                  q_mem [mtg_pkg::QUEUE_DEPTH];
    logic [mtg_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [mtg_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [mtg_pkg::QCNT_W-1:0]      count_reg;
    logic                            push;
    logic                            do_pop;
    mtg_pkg::item_t                  new_item;

    localparam logic [mtg_pkg::QPTR_W-1:0] PTR_LAST = mtg_pkg::QPTR_W'(mtg_pkg::QUEUE_DEPTH - 1);
    localparam logic [mtg_pkg::QCNT_W-1:0] CNT_FULL = mtg_pkg::QCNT_W'(mtg_pkg::QUEUE_DEPTH);

    assign item_stall    = (count_reg == CNT_FULL);
    assign push          = item_valid && !item_stall;
    assign do_pop        = pop && (count_reg != '0);
    assign new_item.cmd  = action ? mtg_pkg::CMD_NEXT : mtg_pkg::CMD_SEED;
    assign new_item.seed = seed_value;
    assign head.valid    = (count_reg != '0);
    assign head.item     = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/mtg_back.sv
// ----------------------------------------------------------------------------
// mtg_back
// Engine: owns the 624-word pool RAM, runs the seed recurrence and the
// in-place twist one word per cycle, and tempers words into the output slot.
// ----------------------------------------------------------------------------
module mtg_back (
    input  logic           clk,
    input  logic           rst_n,
    input  mtg_pkg::head_t head,
    output logic           pop,
    output logic           word_valid,
    input  logic           word_stall,
    output logic [31:0]    random_word
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_REGEN,
        ST_READ
    } state_t;

    state_t                        state_reg, state_next;
    logic                          seeded_reg, seeded_next;
    logic [mtg_pkg::ADDR_W-1:0]    index_reg, index_next;
    logic [mtg_pkg::ADDR_W-1:0]    cnt_reg, cnt_next;
    logic [mtg_pkg::ADDR_W-1:0]    mid_reg, mid_next;
    logic                          iss_done_reg, iss_done_next;
    logic                          dat_prime_reg, dat_prime_next;
    logic                          dat_valid_reg, dat_valid_next;
    logic [mtg_pkg::ADDR_W-1:0]    dat_k_reg, dat_k_next;
    logic [31:0]                   prev_reg, prev_next;
    logic [31:0]                   cur_reg, cur_next;
    logic [31:0]                   word_reg, word_next;
    logic                          word_valid_reg, word_valid_next;

    logic [31:0]                   mem [mtg_pkg::STATE_WORDS];
    logic [31:0]                   rd_a_reg;
    logic [31:0]                   rd_b_reg;
    logic                          we;
    logic [mtg_pkg::ADDR_W-1:0]    wa;
    logic [31:0]                   wd;
    logic [mtg_pkg::ADDR_W-1:0]    addr_a;
    logic [mtg_pkg::ADDR_W-1:0]    addr_b;

    logic                          slot_free;
    logic [31:0]                   seed_mix;
    logic [31:0]                   seed_prod;
    logic [31:0]                   seed_word;
    logic [31:0]                   twist_y;
    logic [31:0]                   twist_word;
    logic [mtg_pkg::ADDR_W-1:0]    nxt_addr;
    logic [mtg_pkg::ADDR_W-1:0]    mid_inc;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
        y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    assign word_valid  = word_valid_reg;
    assign random_word = word_reg;
    assign slot_free   = !word_valid_reg || !word_stall;

    assign seed_mix   = prev_reg ^ (prev_reg >> 30);
    assign seed_prod  = seed_mix * mtg_pkg::SEED_MUL;
    assign seed_word  = seed_prod + 32'(cnt_reg);
    assign twist_y    = (cur_reg & mtg_pkg::TOP_BIT_MASK) | (rd_a_reg & mtg_pkg::LOW_BITS_MASK);
    assign twist_word = rd_b_reg ^ (twist_y >> 1) ^ (twist_y[0] ? mtg_pkg::TWIST_MATRIX : 32'd0);
    assign nxt_addr   = (cnt_reg == mtg_pkg::LAST_ADDR) ? '0 : cnt_reg + 1'b1;
    assign mid_inc    = (mid_reg == mtg_pkg::LAST_ADDR) ? '0 : mid_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    always_comb
    begin
        state_next      = state_reg;
        seeded_next     = seeded_reg;
        index_next      = index_reg;
        cnt_next        = cnt_reg;
        mid_next        = mid_reg;
        iss_done_next   = iss_done_reg;
        dat_prime_next  = dat_prime_reg;
        dat_valid_next  = dat_valid_reg;
        dat_k_next      = dat_k_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        word_next       = word_reg;
        word_valid_next = word_valid_reg && word_stall;
        pop             = 1'b0;
        we              = 1'b0;
        wa              = '0;
        wd              = '0;
        addr_a          = '0;
        addr_b          = mid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.item.cmd == mtg_pkg::CMD_SEED)
                    begin
                        pop         = 1'b1;
                        we          = 1'b1;
                        wa          = '0;
                        wd          = head.item.seed;
                        prev_next   = head.item.seed;
                        cnt_next    = mtg_pkg::ADDR_W'(1);
                        seeded_next = 1'b1;
                        state_next  = ST_SEED;
                    end
                    else if (slot_free)
                    begin
                        pop = 1'b1;
                        if (!seeded_reg)
                        begin
                            // unseeded: the pool RAM is not initialised, so a zero word is shown without a pool read
                            word_next       = '0;
                            word_valid_next = 1'b1;
                        end
                        else if (index_reg >= mtg_pkg::POOL_END)
                        begin
                            addr_a         = '0;
                            dat_prime_next = 1'b1;
                            dat_valid_next = 1'b0;
                            cnt_next       = '0;
                            mid_next       = mtg_pkg::MID_START;
                            iss_done_next  = 1'b0;
                            state_next     = ST_REGEN;
                        end
                        else
                        begin
                            addr_a     = index_reg;
                            index_next = index_reg + 1'b1;
                            state_next = ST_READ;
                        end
                    end
                end
            end

            ST_SEED:
            begin
                we        = 1'b1;
                wa        = cnt_reg;
                wd        = seed_word;
                prev_next = seed_word;
                if (cnt_reg == mtg_pkg::LAST_ADDR)
                begin
                    index_next = mtg_pkg::POOL_END;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_REGEN:
            begin
                dat_prime_next = 1'b0;
                dat_valid_next = 1'b0;
                if (dat_prime_reg)
                begin
                    cur_next = rd_a_reg;
                end
                if (!iss_done_reg)
                begin
                    addr_a         = nxt_addr;
                    addr_b         = mid_reg;
                    dat_valid_next = 1'b1;
                    dat_k_next     = cnt_reg;
                    cnt_next       = nxt_addr;
                    mid_next       = mid_inc;
                    if (cnt_reg == mtg_pkg::LAST_ADDR)
                    begin
                        iss_done_next = 1'b1;
                    end
                end
                if (dat_valid_reg)
                begin
                    we       = 1'b1;
                    wa       = dat_k_reg;
                    wd       = twist_word;
                    cur_next = rd_a_reg;
                    if (dat_k_reg == mtg_pkg::LAST_ADDR)
                    begin
                        addr_a     = '0;
                        index_next = mtg_pkg::ADDR_W'(1);
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                word_next       = temper(rd_a_reg);
                word_valid_next = 1'b1;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            seeded_reg     <= 1'b0;
            index_reg      <= '0;
            iss_done_reg   <= 1'b0;
            dat_prime_reg  <= 1'b0;
            dat_valid_reg  <= 1'b0;
            word_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            mid_reg        <= '0;
            dat_k_reg      <= '0;
            prev_reg       <= '0;
            cur_reg        <= '0;
            word_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            seeded_reg     <= seeded_next;
            index_reg      <= index_next;
            iss_done_reg   <= iss_done_next;
            dat_prime_reg  <= dat_prime_next;
            dat_valid_reg  <= dat_valid_next;
            word_valid_reg <= word_valid_next;
            cnt_reg        <= cnt_next;
            mid_reg        <= mid_next;
            dat_k_reg      <= dat_k_next;
            prev_reg       <= prev_next;
            cur_reg        <= cur_next;
            word_reg       <= word_next;
        end
    end

endmodule

### hdl/mt19937_word_generator.sv
// A request goes via the queue, a pool RAM read and the output register (no read before a seed).
// Each word: pool RAM read, then temper into the output register; one request at a time.
// A request that finds the pool used up first runs the twist, one word a cycle.
// A seed busies the engine for all 624 words, one a cycle through the seed multiplier.
// Reset: asynchronous, active low; words read zero until the first seed, no clearing pass.
// ----------------------------------------------------------------------------
// mt19937_word_generator
// MT19937 32-bit word generator: seed and request items in, tempered words
// out, with a queue between the input side and the pool engine.
// ----------------------------------------------------------------------------
module mt19937_word_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        action,
    input  logic [31:0] seed_value,
    output logic        word_valid,
    input  logic        word_stall,
    output logic [31:0] random_word
);

    mtg_pkg::head_t head;
    logic           pop;

    mtg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .action     (action),
        .seed_value (seed_value),
        .head       (head),
        .pop        (pop)
    );

    mtg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .random_word (random_word)
    );

endmodule

### hdl/mtg_checker.sv
// ----------------------------------------------------------------------------
// mtg_checker
// Port-level checks for the word generator: output handshake, words owed
// to requests, and zero output before any seed.
// ----------------------------------------------------------------------------
module mtg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        action,
    input logic        word_valid,
    input logic        word_stall,
    input logic [31:0] random_word
);

    logic [2:0] pending_reg;
    logic       seen_seed_reg;
    logic       req_xfer;
    logic       word_xfer;

    assign req_xfer  = item_valid && !item_stall && action;
    assign word_xfer = word_valid && !word_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            seen_seed_reg <= 1'b0;
        end
        else
        begin
            if (req_xfer && !word_xfer)
            begin
                pending_reg <= pending_reg + 1'b1;
            end
            else if (word_xfer && !req_xfer)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
            if (item_valid && !item_stall && !action)
            begin
                seen_seed_reg <= 1'b1;
            end
        end
    end

    a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_stall |=> word_valid)
        else $error("word_valid dropped while stalled");

    a_word_stable: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_stall |=> $stable(random_word))
        else $error("random_word changed while stalled");

    a_word_owed: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> pending_reg != 3'd0)
        else $error("word shown with no request outstanding");

    a_unseeded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !seen_seed_reg |-> random_word == 32'd0)
        else $error("nonzero word before any seed");

endmodule

bind mt19937_word_generator mtg_checker u_mtg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .action      (action),
    .word_valid  (word_valid),
    .word_stall  (word_stall),
    .random_word (random_word)
);
